// File: sv/epc_pkg.sv
package epc_pkg;

  // Fixed field widths of the controller.
  localparam int ANGLE_BITS     = 12;
  localparam int POSITION_BITS  = 32;
  localparam int GAIN_FRAC_BITS = 16;

  localparam int COEF_W      = 20;
  localparam int ALPHA_W     = 17;
  localparam int ALPHA_FRAC  = 16;
  localparam int LIMIT_W     = 16;
  localparam int VEL_STATE_W = 24;
  localparam int VEL_OUT_W   = 20;
  localparam int VEL_FRAC    = 8;

  // Derived datapath widths.
  localparam int DELTA_W   = ANGLE_BITS + 1;
  localparam int ERR_W     = POSITION_BITS + 1;
  localparam int TERM_W    = POSITION_BITS + 2;
  localparam int TERM_LO_W = TERM_W / 2;
  localparam int TERM_HI_W = TERM_W - TERM_LO_W;
  localparam int AD_W      = ALPHA_W + 1 + DELTA_W;
  localparam int VPROD_W   = ALPHA_W + 1 + VEL_STATE_W;
  localparam int VACC_W    = VPROD_W + 1;
  localparam int PP_LO_W   = COEF_W + 1 + TERM_LO_W + 1;
  localparam int PP_HI_W   = COEF_W + 1 + TERM_HI_W;
  localparam int INC_W     = PP_HI_W + 1 + TERM_LO_W + 1;
  localparam int DRIVE_W   = LIMIT_W + GAIN_FRAC_BITS + 2;
  localparam int ACC_W     = INC_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_POSITION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_COEF      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_COEF      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_COEF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT  = 3'd4;

  localparam logic [POSITION_BITS-1:0] RST_REF_POSITION = 32'd228;
  localparam logic [COEF_W-1:0]        RST_KP_COEF      = 20'd24480;
  localparam logic [COEF_W-1:0]        RST_KI_COEF      = 20'd29;
  localparam logic [ALPHA_W-1:0]       RST_ALPHA_COEF   = 17'd58982;
  localparam logic [LIMIT_W-1:0]       RST_DRIVE_LIMIT  = 16'd256;

  // Load strobes of the five pipeline registers behind the input register.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

// File: sv/encoder_position_pi_controller_top.sv
// Encoder position PI controller.
// Input channel (in_valid / in_ready / in_raw_angle) takes one encoder angle
// beat per control tick. The very first beat after reset only records the
// angle and returns a result with out_primed_only set, zero drive level and
// the current position, velocity and error.
// Result channel (out_valid / out_ready / out_*) gives one beat per input
// beat: drive magnitude and direction, position, filtered velocity and error.
// The beat passes an input register followed by five pipeline registers, the last
// being the output register. Throughput is one beat per cycle while the receiver
// keeps taking results; the loops that set this figure are the velocity filter
// (one multiply of the old velocity per beat) and the drive accumulator (one add
// and clamp per beat), each closing through a single state register.
// When the receiver stalls, beats already inside keep moving into empty
// stages, so in_ready stays high until every register holds a beat.
// Reset (rst_n, synchronous) empties the pipeline, clears position, velocity,
// error and drive history and returns the configuration to its defaults.
// Configuration writes (cfg_we / cfg_index / cfg_wdata) take effect at once
// and must be issued only while no beat is in flight.
module encoder_position_pi_controller_top import epc_pkg::*; (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic        [ANGLE_BITS-1:0]    in_raw_angle,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic        [LIMIT_W-1:0]       out_drive_level,
  output logic                            out_reverse,
  output logic signed [POSITION_BITS-1:0] out_position,
  output logic signed [VEL_OUT_W-1:0]     out_velocity,
  output logic signed [ERR_W-1:0]         out_pos_error,
  output logic                            out_primed_only,

  input  logic                            cfg_we,
  input  logic        [CFG_IDX_W-1:0]     cfg_index,
  input  logic        [CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int NSTAGE = 6;

  // Configuration registers.
  logic signed [POSITION_BITS-1:0] ref_position_r;
  logic        [COEF_W-1:0]        kp_coef_r;
  logic        [COEF_W-1:0]        ki_coef_r;
  logic        [ALPHA_W-1:0]       alpha_coef_r;
  logic        [LIMIT_W-1:0]       drive_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_position_r <= RST_REF_POSITION;
      kp_coef_r      <= RST_KP_COEF;
      ki_coef_r      <= RST_KI_COEF;
      alpha_coef_r   <= RST_ALPHA_COEF;
      drive_limit_r  <= RST_DRIVE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REF_POSITION: ref_position_r <= cfg_wdata[POSITION_BITS-1:0];
        CFG_KP_COEF:      kp_coef_r      <= cfg_wdata[COEF_W-1:0];
        CFG_KI_COEF:      ki_coef_r      <= cfg_wdata[COEF_W-1:0];
        CFG_ALPHA_COEF:   alpha_coef_r   <= cfg_wdata[ALPHA_W-1:0];
        CFG_DRIVE_LIMIT:  drive_limit_r  <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline occupancy. Each stage loads when the stage before holds a beat
  // and it is empty or being emptied itself, so bubbles are squeezed out.
  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] v_nxt;
  logic [NSTAGE-1:0] rdy;
  logic [NSTAGE:0]   fire;
  stage_en_t         en;

  always_comb begin
    rdy[NSTAGE-1] = !v_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    fire[0] = in_valid && rdy[0];
    for (int k = 1; k < NSTAGE; k++) begin
      fire[k] = v_r[k-1] && rdy[k];
    end
    fire[NSTAGE] = v_r[NSTAGE-1] && out_ready;
    for (int k = 0; k < NSTAGE; k++) begin
      v_nxt[k] = fire[k] || (v_r[k] && !fire[k+1]);
    end
    en.s1 = fire[1];
    en.s2 = fire[2];
    en.s3 = fire[3];
    en.s4 = fire[4];
    en.s5 = fire[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTAGE-1];

  // Input register.
  logic [ANGLE_BITS-1:0] angle_r;

  always_ff @(posedge clk) begin
    if (fire[0]) begin
      angle_r <= in_raw_angle;
    end
  end

  // Position tracking and error terms (stages one and two).
  logic                            s1_prime;
  logic signed [DELTA_W-1:0]       s1_delta;
  logic                            s2_prime;
  logic signed [POSITION_BITS-1:0] s2_pos;
  logic signed [ERR_W-1:0]         s2_err;
  logic signed [TERM_W-1:0]        s2_dterm;
  logic signed [TERM_W-1:0]        s2_sterm;

  epc_track u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .angle        (angle_r),
    .ref_position (ref_position_r),
    .s1_prime_r   (s1_prime),
    .s1_delta_r   (s1_delta),
    .s2_prime_r   (s2_prime),
    .s2_pos_r     (s2_pos),
    .s2_err_r     (s2_err),
    .s2_dterm_r   (s2_dterm),
    .s2_sterm_r   (s2_sterm)
  );

  // Velocity filter (stages two and three).
  logic signed [VEL_OUT_W-1:0] s3_vel;

  epc_velocity u_velocity (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .alpha_coef (alpha_coef_r),
    .s1_prime   (s1_prime),
    .s1_delta   (s1_delta),
    .s3_vel_r   (s3_vel)
  );

  // PI drive law (stages three to five).
  logic [LIMIT_W-1:0] drive_level;
  logic               drive_reverse;

  epc_drive u_drive (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .kp_coef     (kp_coef_r),
    .ki_coef     (ki_coef_r),
    .drive_limit (drive_limit_r),
    .s2_prime    (s2_prime),
    .s2_dterm    (s2_dterm),
    .s2_sterm    (s2_sterm),
    .level_r     (drive_level),
    .reverse_r   (drive_reverse)
  );

  // Side fields travel alongside the drive computation.
  logic signed [POSITION_BITS-1:0] p3_pos_r;
  logic signed [ERR_W-1:0]         p3_err_r;
  logic                            p3_prime_r;
  logic signed [POSITION_BITS-1:0] p4_pos_r;
  logic signed [ERR_W-1:0]         p4_err_r;
  logic                            p4_prime_r;
  logic signed [VEL_OUT_W-1:0]     p4_vel_r;
  logic signed [POSITION_BITS-1:0] out_pos_r;
  logic signed [ERR_W-1:0]         out_err_r;
  logic                            out_prime_r;
  logic signed [VEL_OUT_W-1:0]     out_vel_r;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      p3_pos_r   <= s2_pos;
      p3_err_r   <= s2_err;
      p3_prime_r <= s2_prime;
    end
    if (en.s4) begin
      p4_pos_r   <= p3_pos_r;
      p4_err_r   <= p3_err_r;
      p4_prime_r <= p3_prime_r;
      p4_vel_r   <= s3_vel;
    end
    if (en.s5) begin
      out_pos_r   <= p4_pos_r;
      out_err_r   <= p4_err_r;
      out_prime_r <= p4_prime_r;
      out_vel_r   <= p4_vel_r;
    end
  end

  assign out_drive_level = drive_level;
  assign out_reverse     = drive_reverse;
  assign out_position    = out_pos_r;
  assign out_velocity    = out_vel_r;
  assign out_pos_error   = out_err_r;
  assign out_primed_only = out_prime_r;

`ifndef NO_ASSERTIONS
  // An empty input register can always take a beat.
  a_empty_input_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_ready)
    else $error("input register empty but in_ready low");

  // A priming beat never carries drive.
  a_prime_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_primed_only) |-> (out_drive_level == '0))
    else $error("priming result carries a drive level");

  // A taken result with nothing behind it leaves the output empty.
  a_output_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !v_r[NSTAGE-2]) |=> !out_valid)
    else $error("output stayed valid with no beat behind it");
`endif

endmodule

// File: sv/epc_track.sv
module epc_track import epc_pkg::*; (
  input  logic                            clk,
  input  logic                            rst_n,
  input  stage_en_t                       en,
  input  logic        [ANGLE_BITS-1:0]    angle,
  input  logic signed [POSITION_BITS-1:0] ref_position,
  output logic                            s1_prime_r,
  output logic signed [DELTA_W-1:0]       s1_delta_r,
  output logic                            s2_prime_r,
  output logic signed [POSITION_BITS-1:0] s2_pos_r,
  output logic signed [ERR_W-1:0]         s2_err_r,
  output logic signed [TERM_W-1:0]        s2_dterm_r,
  output logic signed [TERM_W-1:0]        s2_sterm_r
);

  localparam logic signed [DELTA_W:0] HALF_D = (DELTA_W+1)'(1 << (ANGLE_BITS - 1));
  localparam logic signed [DELTA_W:0] FULL_D = (DELTA_W+1)'(1 << ANGLE_BITS);
  localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};

  logic                            primed_r;
  logic        [ANGLE_BITS-1:0]    last_sample_r;
  logic signed [POSITION_BITS-1:0] pos_r;
  logic signed [ERR_W-1:0]         prev_err_r;
  logic signed [POSITION_BITS-1:0] s1_pos_r;

  logic signed [DELTA_W:0]         diff;
  logic signed [DELTA_W-1:0]       delta;
  logic signed [POSITION_BITS:0]   pos_sum;
  logic signed [POSITION_BITS-1:0] pos_sat;
  logic signed [ERR_W-1:0]         err;
  logic signed [TERM_W-1:0]        dterm;
  logic signed [TERM_W-1:0]        sterm;

  // Unwrap the angle change at half a turn, then add it with saturation.
  always_comb begin
    diff = $signed({2'b00, angle}) - $signed({2'b00, last_sample_r});
    if (diff > HALF_D) begin
      diff = diff - FULL_D;
    end else if (diff < -HALF_D) begin
      diff = diff + FULL_D;
    end
    delta   = diff[DELTA_W-1:0];
    pos_sum = pos_r + delta;
    if (pos_sum[POSITION_BITS] != pos_sum[POSITION_BITS-1]) begin
      pos_sat = pos_sum[POSITION_BITS] ? POS_MIN : POS_MAX;
    end else begin
      pos_sat = pos_sum[POSITION_BITS-1:0];
    end
  end

  always_comb begin
    err   = ref_position - s1_pos_r;
    dterm = err - prev_err_r;
    sterm = err + prev_err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r      <= 1'b0;
      last_sample_r <= '0;
      pos_r         <= '0;
      prev_err_r    <= '0;
    end else begin
      if (en.s1) begin
        last_sample_r <= angle;
        primed_r      <= 1'b1;
        if (primed_r) begin
          pos_r <= pos_sat;
        end
      end
      if (en.s2 && !s1_prime_r) begin
        prev_err_r <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_prime_r <= !primed_r;
      s1_delta_r <= delta;
      s1_pos_r   <= primed_r ? pos_sat : pos_r;
    end
    if (en.s2) begin
      s2_prime_r <= s1_prime_r;
      s2_pos_r   <= s1_pos_r;
      s2_err_r   <= err;
      s2_dterm_r <= dterm;
      s2_sterm_r <= sterm;
    end
  end

endmodule

// File: sv/epc_velocity.sv
module epc_velocity import epc_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  stage_en_t                   en,
  input  logic        [ALPHA_W-1:0]   alpha_coef,
  input  logic                        s1_prime,
  input  logic signed [DELTA_W-1:0]   s1_delta,
  output logic signed [VEL_OUT_W-1:0] s3_vel_r
);

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC);
  localparam logic signed [VACC_W-1:0] ROUND_HALF = VACC_W'(1 << (ALPHA_FRAC - 1));
  localparam logic signed [VEL_OUT_W-1:0] VOUT_MAX = {1'b0, {(VEL_OUT_W-1){1'b1}}};
  localparam logic signed [VEL_OUT_W-1:0] VOUT_MIN = {1'b1, {(VEL_OUT_W-1){1'b0}}};

  logic signed [AD_W-1:0]        ad_r;
  logic                          s2_prime_r;
  logic signed [VEL_STATE_W-1:0] vel_r;

  logic        [ALPHA_W-1:0]     alpha_eff;
  logic        [ALPHA_W-1:0]     keep_w;
  logic signed [AD_W-1:0]        ad;
  logic signed [VPROD_W-1:0]     vprod;
  logic signed [VACC_W-1:0]      ad_ext;
  logic signed [VACC_W-1:0]      vprod_ext;
  logic signed [VACC_W-1:0]      vacc;
  logic signed [VEL_STATE_W-1:0] vel_new;
  logic signed [VEL_STATE_W-1:0] vel_sel;
  logic signed [VEL_OUT_W-1:0]   vel_sat;
  logic [VEL_STATE_W-VEL_OUT_W:0] vel_top;

  always_comb begin
    alpha_eff = (alpha_coef > ALPHA_ONE) ? ALPHA_ONE : alpha_coef;
    keep_w    = ALPHA_ONE - alpha_eff;
    ad        = $signed({1'b0, alpha_eff}) * s1_delta;
  end

  // Filter loop: one multiply of the old velocity per beat.
  always_comb begin
    vprod     = $signed({1'b0, keep_w}) * vel_r;
    ad_ext    = ad_r;
    vprod_ext = vprod;
    vacc      = (ad_ext <<< VEL_FRAC) + vprod_ext + ROUND_HALF;
    vel_new   = vacc[ALPHA_FRAC +: VEL_STATE_W];
    vel_sel   = s2_prime_r ? vel_r : vel_new;
    vel_top   = vel_sel[VEL_STATE_W-1:VEL_OUT_W-1];
    if ((vel_top != '0) && (vel_top != '1)) begin
      vel_sat = vel_sel[VEL_STATE_W-1] ? VOUT_MIN : VOUT_MAX;
    end else begin
      vel_sat = vel_sel[VEL_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r <= '0;
    end else if (en.s3 && !s2_prime_r) begin
      vel_r <= vel_new;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      ad_r       <= ad;
      s2_prime_r <= s1_prime;
    end
    if (en.s3) begin
      s3_vel_r <= vel_sat;
    end
  end

endmodule

// File: sv/epc_drive.sv
module epc_drive import epc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  stage_en_t                en,
  input  logic        [COEF_W-1:0] kp_coef,
  input  logic        [COEF_W-1:0] ki_coef,
  input  logic       [LIMIT_W-1:0] drive_limit,
  input  logic                     s2_prime,
  input  logic signed [TERM_W-1:0] s2_dterm,
  input  logic signed [TERM_W-1:0] s2_sterm,
  output logic       [LIMIT_W-1:0] level_r,
  output logic                     reverse_r
);

  logic signed [PP_LO_W-1:0] pp_dl_r;
  logic signed [PP_HI_W-1:0] pp_dh_r;
  logic signed [PP_LO_W-1:0] pp_sl_r;
  logic signed [PP_HI_W-1:0] pp_sh_r;
  logic                      s3_prime_r;
  logic signed [INC_W-1:0]   inc_r;
  logic                      s4_prime_r;
  logic signed [DRIVE_W-1:0] drive_r;

  logic signed [COEF_W:0]      kp_s;
  logic signed [COEF_W:0]      ki_s;
  logic signed [TERM_LO_W:0]   dlo;
  logic signed [TERM_HI_W-1:0] dhi;
  logic signed [TERM_LO_W:0]   slo;
  logic signed [TERM_HI_W-1:0] shi;

  logic signed [INC_W-1:0]   hi_sum;
  logic signed [INC_W-1:0]   lo_sum;
  logic signed [INC_W-1:0]   inc;

  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   lim;
  logic signed [ACC_W-1:0]   acc_clip;
  logic signed [DRIVE_W-1:0] drive_nxt;
  logic signed [DRIVE_W-1:0] drive_mag;

  // Error terms are split in halves so each product stays near 20 x 17 bits.
  always_comb begin
    kp_s = $signed({1'b0, kp_coef});
    ki_s = $signed({1'b0, ki_coef});
    dlo  = $signed({1'b0, s2_dterm[TERM_LO_W-1:0]});
    dhi  = s2_dterm[TERM_W-1:TERM_LO_W];
    slo  = $signed({1'b0, s2_sterm[TERM_LO_W-1:0]});
    shi  = s2_sterm[TERM_W-1:TERM_LO_W];
  end

  always_comb begin
    hi_sum = pp_dh_r;
    hi_sum = hi_sum + pp_sh_r;
    lo_sum = pp_dl_r;
    lo_sum = lo_sum + pp_sl_r;
    inc    = (hi_sum <<< TERM_LO_W) + lo_sum;
  end

  // Drive loop: accumulate and clamp to the symmetric limit.
  always_comb begin
    acc = drive_r;
    acc = acc + inc_r;
    lim = $signed({{(ACC_W-LIMIT_W-GAIN_FRAC_BITS){1'b0}}, drive_limit,
                   {GAIN_FRAC_BITS{1'b0}}});
    if (acc > lim) begin
      acc_clip = lim;
    end else if (acc < -lim) begin
      acc_clip = -lim;
    end else begin
      acc_clip = acc;
    end
    drive_nxt = acc_clip[DRIVE_W-1:0];
    drive_mag = drive_nxt[DRIVE_W-1] ? -drive_nxt : drive_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r   <= '0;
      reverse_r <= 1'b0;
    end else if (en.s5 && !s4_prime_r) begin
      drive_r <= drive_nxt;
      if (drive_nxt > 0) begin
        reverse_r <= 1'b0;
      end else if (drive_nxt < 0) begin
        reverse_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      pp_dl_r    <= kp_s * dlo;
      pp_dh_r    <= kp_s * dhi;
      pp_sl_r    <= ki_s * slo;
      pp_sh_r    <= ki_s * shi;
      s3_prime_r <= s2_prime;
    end
    if (en.s4) begin
      inc_r      <= inc;
      s4_prime_r <= s3_prime_r;
    end
    if (en.s5) begin
      if (s4_prime_r) begin
        level_r <= '0;
      end else begin
        level_r <= drive_mag[GAIN_FRAC_BITS +: LIMIT_W];
      end
    end
  end

endmodule
